// File: sv/sdcfg_pkg.sv
// Shared types and constants for the stepper driver configuration frame generator.
// Used by sdcfg_ctrl, sdcfg_dp and the top level; depends on nothing else.
`default_nettype none

package sdcfg_pkg;

	localparam int NUM_DRIVERS = 5;
	localparam int DRV_AW      = (NUM_DRIVERS > 1) ? $clog2(NUM_DRIVERS) : 1;
	localparam int CS_W        = 5;
	localparam int WORD_W      = 20;

	// shadow reset values
	localparam logic [WORD_W-1:0] RST_DCTRL = 20'h00204;
	localparam logic [WORD_W-1:0] RST_CHOP  = 20'h901B0;
	localparam logic [WORD_W-1:0] RST_COOL  = 20'hA0000;
	localparam logic [WORD_W-1:0] RST_SGCS  = 20'hC0000;
	localparam logic [WORD_W-1:0] RST_DCONF = 20'hE0000;

	// current scaling: high sense range above I_SPLIT
	localparam logic [15:0] I_SPLIT   = 16'd1650;
	localparam logic [15:0] I_MAX     = 16'd2000;
	localparam logic [15:0] I_MIN     = 16'd50;
	localparam logic [15:0] OFS_HI    = 16'd1500;
	localparam logic [15:0] OFS_LO    = 16'd800;
	localparam logic [11:0] DIV_HI    = 12'd3050;
	localparam logic [11:0] DIV_LO    = 12'd1650;

	// floor(n / div) as (n * rcp) >> RCP_SH, exact for every 16-bit n
	localparam int          RCP_SH    = 28;
	localparam logic [17:0] RCP_HI    =
		18'(((1 << RCP_SH) + int'(DIV_HI) - 1) / int'(DIV_HI));
	localparam logic [17:0] RCP_LO    =
		18'(((1 << RCP_SH) + int'(DIV_LO) - 1) / int'(DIV_LO));

	typedef enum logic [2:0] {
		CMD_INIT    = 3'd0,
		CMD_CURRENT = 3'd1,
		CMD_ENABLE  = 3'd2,
		CMD_MSTEP   = 3'd3,
		CMD_CHOP    = 3'd4,
		CMD_STATUS  = 3'd5,
		CMD_DECODE  = 3'd6,
		CMD_QUERY   = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		FR_NONE,
		FR_CHOP,
		FR_COOL,
		FR_SGCS,
		FR_DCONF,
		FR_DCTRL
	} frame_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_APPLY,
		ST_EMIT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic       load;
		logic       div_step;
		logic       apply;
		logic       emit;
		logic       last;
		logic [2:0] idx;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic       is_cur;
		logic [2:0] n_res;
	} dp_status_t;

endpackage

`default_nettype wire

// File: sv/sdcfg_ctrl.sv
// Controller state machine: sequences load, CS division, shadow update and frame emission.
// Depends on sdcfg_pkg.
`default_nettype none

module sdcfg_ctrl
	import sdcfg_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire dp_status_t status,
	output      dp_cmd_t    dp_cmd,
	output      logic       busy
);

	state_t     state_q, state_d;
	logic [2:0] cnt_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_d = ST_LOAD;
			ST_LOAD:  state_d = status.is_cur ? ST_DIV : ST_APPLY;
			ST_DIV:   state_d = ST_APPLY;
			ST_APPLY: state_d = ST_EMIT;
			ST_EMIT:  if (cnt_q == status.n_res - 3'd1) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		dp_cmd          = '0;
		dp_cmd.idx      = cnt_q;
		dp_cmd.load     = (state_q == ST_IDLE) && start;
		dp_cmd.div_step = (state_q == ST_DIV);
		dp_cmd.apply    = (state_q == ST_APPLY);
		dp_cmd.emit     = (state_q == ST_EMIT);
		dp_cmd.last     = (state_q == ST_EMIT) && (cnt_q == status.n_res - 3'd1);
		busy            = (state_q != ST_IDLE);
	end

	// restart the counter on every state change
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? 3'd0 : cnt_q + 3'd1;
		end
	end

endmodule

`default_nettype wire

// File: sv/sdcfg_dp.sv
// Datapath: command latch, shadow register file, CS reciprocal multiplier and result registers.
// Depends on sdcfg_pkg.
`default_nettype none

module sdcfg_dp
	import sdcfg_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire dp_cmd_t             dp_cmd,
	input  wire logic [2:0]          cmd,
	input  wire logic [2:0]          drive,
	input  wire logic [15:0]         current_ma,
	input  wire logic                enable_on,
	input  wire logic [16:0]         setting_value,
	input  wire logic                interpolate,
	input  wire logic [23:0]         raw_reply,
	output      dp_status_t          status,
	output      logic                strobe,
	output      logic [2:0]          drive_select,
	output      logic [WORD_W-1:0]   spi_word,
	output      logic                frame_valid,
	output      logic                last,
	output      logic                accepted,
	output      logic [7:0]          status_bits,
	output      logic [8:0]          microstep_count,
	output      logic                interpolation_on
);

	// latched command
	cmd_t        cmd_q;
	logic [2:0]  drive_q;
	logic        en_q;
	logic [16:0] val_q;
	logic        ip_q;
	logic [7:0]  reply_q;
	logic        hi_q;
	logic [17:0] rcp_q;
	logic [15:0] num_q;
	logic [CS_W-1:0] quo_q;

	// shadows
	logic [WORD_W-1:0] dctrl_q [NUM_DRIVERS];
	logic [WORD_W-1:0] chop_q  [NUM_DRIVERS];
	logic [WORD_W-1:0] cool_q  [NUM_DRIVERS];
	logic [WORD_W-1:0] sgcs_q  [NUM_DRIVERS];
	logic [WORD_W-1:0] dconf_q [NUM_DRIVERS];

	// result registers
	logic              strobe_q;
	logic [2:0]        drive_sel_q;
	logic [WORD_W-1:0] word_q;
	logic              fvalid_q;
	logic              last_q;
	logic              acc_q;
	logic [7:0]        stat_q;
	logic [8:0]        mcount_q;
	logic              intp_q;

	logic              in_hi;
	logic [15:0]       i_clamp;
	logic [15:0]       num;
	logic              in_range;
	logic [DRV_AW-1:0] sel;
	logic              ms_ok;
	logic [3:0]        ms_sh;
	logic [33:0]       prod;
	frame_sel_t        fsel;
	logic [WORD_W-1:0] fword;

	// clamp and scale the request at accept time
	always_comb begin
		in_hi = (current_ma > I_SPLIT);
		if (in_hi)
			i_clamp = (current_ma > I_MAX) ? I_MAX : current_ma;
		else
			i_clamp = (current_ma < I_MIN) ? I_MIN : current_ma;
		num = {i_clamp[10:0], 5'b0} - (in_hi ? OFS_HI : OFS_LO);
	end

	assign in_range = ({29'd0, drive_q} < NUM_DRIVERS);
	assign sel      = DRV_AW'(drive_q);

	// CS = floor(num / div), taken from the upper product bits
	assign prod = {18'd0, num_q} * {16'd0, rcp_q};

	// microstep count must be a power of two up to 256
	always_comb begin
		ms_sh = '0;
		for (int b = 0; b < 9; b++) begin
			if (val_q[b]) ms_sh = 4'(8 - b);
		end
		ms_ok = (val_q[16:9] == '0) && (val_q[8:0] != '0)
			&& ((val_q[8:0] & (val_q[8:0] - 9'd1)) == '0);
	end

	always_comb begin
		status.is_cur = (cmd_q == CMD_CURRENT);
		if (cmd_q == CMD_DECODE || !in_range)
			status.n_res = 3'd1;
		else if (cmd_q == CMD_INIT)
			status.n_res = 3'd5;
		else if (cmd_q == CMD_CURRENT)
			status.n_res = 3'd2;
		else
			status.n_res = 3'd1;
	end

	// pick the frame for this emit slot
	always_comb begin
		fsel = FR_NONE;
		if (in_range) begin
			unique case (cmd_q)
				CMD_INIT: begin
					unique case (dp_cmd.idx)
						3'd0:    fsel = FR_CHOP;
						3'd1:    fsel = FR_SGCS;
						3'd2:    fsel = FR_DCONF;
						3'd3:    fsel = FR_DCTRL;
						default: fsel = FR_COOL;
					endcase
				end
				CMD_CURRENT: begin
					if (hi_q == (dp_cmd.idx == 3'd0))
						fsel = FR_SGCS;
					else
						fsel = FR_DCONF;
				end
				CMD_ENABLE, CMD_CHOP: fsel = FR_CHOP;
				CMD_MSTEP:            fsel = ms_ok ? FR_DCTRL : FR_NONE;
				CMD_STATUS:           fsel = FR_COOL;
				CMD_DECODE, CMD_QUERY: fsel = FR_NONE;
				default:              fsel = FR_NONE;
			endcase
		end
	end

	always_comb begin
		unique case (fsel)
			FR_CHOP:  fword = chop_q[sel];
			FR_COOL:  fword = cool_q[sel];
			FR_SGCS:  fword = sgcs_q[sel];
			FR_DCONF: fword = dconf_q[sel];
			FR_DCTRL: fword = dctrl_q[sel];
			default:  fword = '0;
		endcase
	end

	// command latch and CS scaling
	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			cmd_q   <= cmd_t'(cmd);
			drive_q <= drive;
			en_q    <= enable_on;
			val_q   <= setting_value;
			ip_q    <= interpolate;
			reply_q <= raw_reply[11:4];
			hi_q    <= in_hi;
			rcp_q   <= in_hi ? RCP_HI : RCP_LO;
			num_q   <= num;
			quo_q   <= '0;
		end else if (dp_cmd.div_step) begin
			quo_q <= prod[RCP_SH+CS_W-1:RCP_SH];
		end
	end

	// shadow update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < NUM_DRIVERS; d++) begin
				dctrl_q[d] <= RST_DCTRL;
				chop_q[d]  <= RST_CHOP;
				cool_q[d]  <= RST_COOL;
				sgcs_q[d]  <= RST_SGCS;
				dconf_q[d] <= RST_DCONF;
			end
		end else if (dp_cmd.apply && in_range) begin
			unique case (cmd_q)
				CMD_INIT: begin
					dctrl_q[sel] <= RST_DCTRL;
					chop_q[sel]  <= RST_CHOP;
					cool_q[sel]  <= RST_COOL;
					sgcs_q[sel]  <= RST_SGCS;
					dconf_q[sel] <= RST_DCONF;
				end
				CMD_CURRENT: begin
					sgcs_q[sel]     <= {sgcs_q[sel][WORD_W-1:CS_W], quo_q};
					dconf_q[sel][6] <= hi_q;
				end
				CMD_ENABLE: chop_q[sel][3:0] <= en_q ? 4'd4 : 4'd0;
				CMD_MSTEP: begin
					if (ms_ok)
						dctrl_q[sel] <= {dctrl_q[sel][19:10], ip_q,
							dctrl_q[sel][8:4], ms_sh};
				end
				CMD_CHOP: chop_q[sel] <= {3'b100, val_q};
				CMD_STATUS, CMD_DECODE, CMD_QUERY: ;
				default: ;
			endcase
		end
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe_q <= 1'b0;
		else
			strobe_q <= dp_cmd.emit;
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.emit) begin
			drive_sel_q <= drive_q;
			word_q      <= fword;
			fvalid_q    <= (fsel != FR_NONE);
			last_q      <= dp_cmd.last;
			acc_q       <= in_range && (cmd_q == CMD_MSTEP) && ms_ok;
			stat_q      <= (cmd_q == CMD_DECODE) ? reply_q : 8'd0;
			if (in_range && cmd_q == CMD_QUERY) begin
				mcount_q <= 9'(9'd256 >> dctrl_q[sel][3:0]);
				intp_q   <= dctrl_q[sel][9];
			end else begin
				mcount_q <= '0;
				intp_q   <= 1'b0;
			end
		end
	end

	assign strobe           = strobe_q;
	assign drive_select     = drive_sel_q;
	assign spi_word         = word_q;
	assign frame_valid      = fvalid_q;
	assign last             = last_q;
	assign accepted         = acc_q;
	assign status_bits      = stat_q;
	assign microstep_count  = mcount_q;
	assign interpolation_on = intp_q;

endmodule

`default_nettype wire

// File: sv/stepper_driver_config_frame_generator.sv
// Top level of the stepper driver configuration frame generator.
// Instantiates sdcfg_ctrl and sdcfg_dp; depends on sdcfg_pkg.
//
// Channel    Handshake          Payload
// command    start / busy       cmd, drive, current_ma, enable_on, setting_value,
//                               interpolate, raw_reply
// result     strobe (1 cycle)   drive_select, spi_word, frame_valid, last, accepted,
//                               status_bits, microstep_count, interpolation_on
//
// A command transfers at a clock edge with start high and busy low.
// Busy then stays high through the load, apply and emit states, plus a divide state
// for set current, where the CS field comes out of a single reciprocal multiplication.
// Results leave one per cycle from the result registers, each in the cycle after its slot;
// init gives five results, set current two, all others and any out-of-range drive one.
// Reset (arst_n low) restores every shadow at once; no clearing pass is needed.
// The receiver cannot stall: every strobe is a completed transfer.
`default_nettype none

module stepper_driver_config_frame_generator
	import sdcfg_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output      logic              busy,
	input  wire logic [2:0]        cmd,
	input  wire logic [2:0]        drive,
	input  wire logic [15:0]       current_ma,
	input  wire logic              enable_on,
	input  wire logic [16:0]       setting_value,
	input  wire logic              interpolate,
	input  wire logic [23:0]       raw_reply,
	output      logic              strobe,
	output      logic [2:0]        drive_select,
	output      logic [WORD_W-1:0] spi_word,
	output      logic              frame_valid,
	output      logic              last,
	output      logic              accepted,
	output      logic [7:0]        status_bits,
	output      logic [8:0]        microstep_count,
	output      logic              interpolation_on
);

	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	// sequencing: load, scale when setting current, update shadows, emit
	sdcfg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (dp_status),
		.dp_cmd (dp_cmd),
		.busy   (busy)
	);

	// shadow registers, CS multiplier and result registers
	sdcfg_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.dp_cmd           (dp_cmd),
		.cmd              (cmd),
		.drive            (drive),
		.current_ma       (current_ma),
		.enable_on        (enable_on),
		.setting_value    (setting_value),
		.interpolate      (interpolate),
		.raw_reply        (raw_reply),
		.status           (dp_status),
		.strobe           (strobe),
		.drive_select     (drive_select),
		.spi_word         (spi_word),
		.frame_valid      (frame_valid),
		.last             (last),
		.accepted         (accepted),
		.status_bits      (status_bits),
		.microstep_count  (microstep_count),
		.interpolation_on (interpolation_on)
	);

	// a run always ends with its last result showing as busy drops
	a_end_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && last)
		else $error("busy dropped without a last result");

	// an accepted command keeps the block busy next cycle
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");

	// a result without a frame carries an empty word
	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !frame_valid |-> spi_word == '0)
		else $error("non-frame result with nonzero word");

	// an applied microstep setting is a single frame that ends its run
	a_accept_frame: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && accepted |-> frame_valid && last)
		else $error("accepted result is not a final frame");

endmodule

`default_nettype wire
